>>> rtl/uvst_pkg.sv
package uvst_pkg;

  // table size and derived widths
  localparam int unsigned CAPACITY = 16;
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned OUT_CNT_W = 5;

  // request queue between front and back
  localparam int unsigned QDEPTH  = 2;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  // operation codes
  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DUP    = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  // one queued request word
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  // queue status seen by the back end
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

endpackage

>>> rtl/uvst_front.sv
module uvst_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [1:0]          func_i,
  input  logic signed [31:0]  value_i,
  output logic                busy_o,
  output uvst_pkg::q_head_t   head_o,
  input  logic                pop_i
);

  uvst_pkg::req_t                    mem_q [uvst_pkg::QDEPTH];
  logic [uvst_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [uvst_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [uvst_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              push;
  logic                              pop;

  // accept a word whenever the queue has room
  assign busy_o = (cnt_q == uvst_pkg::QCNT_W'(uvst_pkg::QDEPTH));
  assign push   = start_i && !busy_o;
  assign pop    = pop_i && (cnt_q != '0);

  assign head_o.valid = (cnt_q != '0);
  assign head_o.req   = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == uvst_pkg::QPTR_W'(uvst_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + uvst_pkg::QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == uvst_pkg::QPTR_W'(uvst_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + uvst_pkg::QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + uvst_pkg::QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - uvst_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].func  <= func_i;
      mem_q[wr_ptr_q].value <= value_i;
    end
  end

endmodule

>>> rtl/uvst_back.sv
module uvst_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  uvst_pkg::q_head_t                 head_i,
  output logic                              pop_o,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [uvst_pkg::CNT_W-1:0]        count_o
);

  localparam logic S_FETCH = 1'b0;
  localparam logic S_EXEC  = 1'b1;

  logic                               state_q, state_d;
  logic [31:0]                        vals_q [uvst_pkg::CAPACITY];
  logic [uvst_pkg::CAPACITY-1:0]      valid_q, valid_d;
  logic [uvst_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [1:0]                         func_q;
  logic [31:0]                        val_q;
  logic [uvst_pkg::CAPACITY-1:0]      hit_q, hit_d;
  logic [uvst_pkg::CAPACITY-1:0]      free_q, free_d;
  logic [uvst_pkg::IDX_W-1:0]         hit_idx;
  logic [uvst_pkg::IDX_W-1:0]         free_idx;
  logic                               wr_en;
  logic                               done_q, done_d;
  logic [1:0]                         status_q, status_d;

  // take a word from the queue whenever the back end is free
  assign pop_o = (state_q == S_FETCH) && head_i.valid;

  // parallel compare against every valid slot
  always_comb begin
    for (int i = 0; i < uvst_pkg::CAPACITY; i++) begin
      hit_d[i] = valid_q[i] && (vals_q[i] == 32'(head_i.req.value));
    end
    free_d = ~valid_q;
  end

  // lowest matching slot and lowest free slot
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = uvst_pkg::CAPACITY - 1; i >= 0; i--) begin
      if (hit_q[i]) begin
        hit_idx = uvst_pkg::IDX_W'(i);
      end
      if (free_q[i]) begin
        free_idx = uvst_pkg::IDX_W'(i);
      end
    end
  end

  // execute the operation on the registered compare results
  always_comb begin
    state_d  = state_q;
    valid_d  = valid_q;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    done_d   = 1'b0;
    status_d = status_q;
    case (state_q)
      S_FETCH: begin
        if (head_i.valid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d  = S_FETCH;
        done_d   = 1'b1;
        status_d = uvst_pkg::ST_OK;
        case (func_q)
          uvst_pkg::OP_LOOKUP: begin
            if (hit_q == '0) begin
              status_d = uvst_pkg::ST_ABSENT;
            end
          end
          uvst_pkg::OP_INSERT: begin
            if (hit_q != '0) begin
              status_d = uvst_pkg::ST_DUP;
            end else if (free_q == '0) begin
              status_d = uvst_pkg::ST_FULL;
            end else begin
              wr_en             = 1'b1;
              valid_d[free_idx] = 1'b1;
              cnt_d             = cnt_q + uvst_pkg::CNT_W'(1);
            end
          end
          uvst_pkg::OP_REMOVE: begin
            if (hit_q == '0) begin
              status_d = uvst_pkg::ST_ABSENT;
            end else begin
              valid_d[hit_idx] = 1'b0;
              cnt_d            = cnt_q - uvst_pkg::CNT_W'(1);
            end
          end
          default: begin
            valid_d = '0;
            cnt_d   = '0;
          end
        endcase
      end
      default: begin
        state_d = S_FETCH;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FETCH;
      valid_q  <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
      status_q <= uvst_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
      status_q <= status_d;
    end
  end

  // latched operation and compare vectors
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      func_q <= head_i.req.func;
      val_q  <= 32'(head_i.req.value);
      hit_q  <= hit_d;
      free_q <= free_d;
    end
  end

  // value store, one write per insert
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vals_q[free_idx] <= val_q;
    end
  end

  assign done_o   = done_q;
  assign status_o = status_q;
  assign count_o  = cnt_q;

endmodule

>>> rtl/unique_value_set_table.sv
// Set of distinct 32-bit values in a 16-slot table with valid marks.
// The result strobe follows the queue slot, the latched compare vectors and
// the done register when the back end is free; words wait in a 2-deep queue.
// The back end takes one word at a time through the compare-then-update pass.
// The receiver cannot stall; done_o is a single-cycle strobe.
// Reset (rst_ni low, async) empties the table and queue; no clearing pass.
module unique_value_set_table (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          func_i,
  input  logic signed [31:0]  value_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [4:0]          entry_count_o
);

  uvst_pkg::q_head_t                  head;
  logic                               pop;
  logic [uvst_pkg::CNT_W-1:0]         count;
  logic [uvst_pkg::CNT_W+uvst_pkg::OUT_CNT_W-1:0] count_ext;

  // front end: accept and queue words
  uvst_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .func_i  (func_i),
    .value_i (value_i),
    .busy_o  (busy_o),
    .head_o  (head),
    .pop_i   (pop)
  );

  // back end: compare, update, report
  uvst_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .done_o   (done_o),
    .status_o (status_o),
    .count_o  (count)
  );

  // count shows its low five bits
  assign count_ext     = {{uvst_pkg::OUT_CNT_W{1'b0}}, count};
  assign entry_count_o = count_ext[uvst_pkg::OUT_CNT_W-1:0];

endmodule
